[hw/rtl/ttyld_pkg.sv]
package ttyld_pkg;

    localparam logic [7:0] BYTE_BS  = 8'h08;
    localparam logic [7:0] BYTE_NL  = 8'h0A;
    localparam logic [7:0] BYTE_CR  = 8'h0D;
    localparam logic [7:0] BYTE_SP  = 8'h20;
    localparam logic [7:0] BYTE_HAT = 8'h5E;
    localparam logic [7:0] BYTE_DEL = 8'h7F;

    localparam logic [1:0] KIND_ECHO   = 2'd0;
    localparam logic [1:0] KIND_DATA   = 2'd1;
    localparam logic [1:0] KIND_SIGNAL = 2'd2;

    localparam logic [7:0] SIG_INTR = 8'd0;
    localparam logic [7:0] SIG_STOP = 8'd1;
    localparam logic [7:0] SIG_QUIT = 8'd2;

    localparam logic [2:0] CFG_INPUT_FLAGS = 3'd0;
    localparam logic [2:0] CFG_LOCAL_FLAGS = 3'd1;
    localparam logic [2:0] CFG_ERASE_CHAR  = 3'd2;
    localparam logic [2:0] CFG_INTR_CHAR   = 3'd3;
    localparam logic [2:0] CFG_SUSP_CHAR   = 3'd4;
    localparam logic [2:0] CFG_QUIT_CHAR   = 3'd5;
    localparam logic [2:0] CFG_FOREGROUND  = 3'd6;

    localparam logic [3:0] RST_INPUT_FLAGS = 4'd8;
    localparam logic [2:0] RST_LOCAL_FLAGS = 3'd7;
    localparam logic [7:0] RST_ERASE_CHAR  = 8'd127;
    localparam logic [7:0] RST_INTR_CHAR   = 8'd3;
    localparam logic [7:0] RST_SUSP_CHAR   = 8'd26;
    localparam logic [7:0] RST_QUIT_CHAR   = 8'd28;

    typedef struct packed {
        logic [3:0] iflag;
        logic [2:0] lflag;
        logic [7:0] erase;
        logic [7:0] intr;
        logic [7:0] susp;
        logic [7:0] quit;
        logic       fg;
    } t_cfg;

    // what one item still has to do, in result order
    typedef struct packed {
        logic       hat;
        logic       chr;
        logic       sig;
        logic       erase;
        logic       nl;
        logic       cr;
        logic       pass;
        logic       st2;
        logic       st1;
        logic [7:0] byte_val;
        logic [7:0] echo_val;
        logic [7:0] sig_code;
    } t_plan;

    typedef enum logic [3:0] {
        S_IDLE,
        S_HAT,
        S_CHR,
        S_SIG,
        S_BS1,
        S_SP,
        S_BS2,
        S_RD,
        S_DATA,
        S_NL,
        S_CR,
        S_PASS,
        S_ST1,
        S_ST2
    } t_state;

    // first step once the echo bytes are out
    function automatic t_state after_echo(t_plan p, logic len_zero);
        t_state s;
        if (p.sig) begin
            s = S_SIG;
        end else if (p.erase) begin
            s = S_BS1;
        end else if (p.nl) begin
            s = len_zero ? S_NL : S_RD;
        end else if (p.pass) begin
            s = S_PASS;
        end else if (p.st2 || p.st1) begin
            s = S_ST1;
        end else begin
            s = S_IDLE;
        end
        return s;
    endfunction

endpackage

[hw/rtl/ttyld_decode.sv]
module ttyld_decode #(
    parameter int LINE_SIZE = 32,
    parameter int LEN_W     = $clog2(LINE_SIZE)
) (
    input  logic [7:0]         i_rx_byte,
    input  ttyld_pkg::t_cfg    i_cfg,
    input  logic [LEN_W-1:0]   i_len,
    output ttyld_pkg::t_plan   o_plan,
    output logic [LEN_W-1:0]   o_len_next
);

    logic [7:0]       c0;
    logic [7:0]       c1;
    logic [7:0]       c;
    logic             ign;
    logic             cntrl;
    logic             esc;
    logic             sig_on;
    logic             sig_hit;
    logic             canon;
    logic             erase_hit;
    logic             nl_hit;
    logic [LEN_W-1:0] len_w;

    always_comb begin
        c0  = i_cfg.iflag[0] ? {1'b0, i_rx_byte[6:0]} : i_rx_byte;
        ign = (c0 == ttyld_pkg::BYTE_CR) && i_cfg.iflag[1];
        if (c0 == ttyld_pkg::BYTE_NL && i_cfg.iflag[2]) begin
            c1 = ttyld_pkg::BYTE_CR;
        end else if (c0 == ttyld_pkg::BYTE_CR && i_cfg.iflag[3]) begin
            c1 = ttyld_pkg::BYTE_NL;
        end else begin
            c1 = c0;
        end
        c = (c1 == ttyld_pkg::BYTE_BS) ? i_cfg.erase : c1;

        cntrl = (c < 8'd32) || (c == ttyld_pkg::BYTE_DEL);
        esc   = i_cfg.lflag[0] && cntrl && (c != i_cfg.erase)
                && (c != ttyld_pkg::BYTE_NL) && (c != ttyld_pkg::BYTE_CR);

        sig_on  = i_cfg.lflag[1] && i_cfg.fg;
        sig_hit = sig_on && ((c == i_cfg.intr) || (c == i_cfg.susp) || (c == i_cfg.quit));
        canon   = i_cfg.lflag[2] && !sig_hit;

        // wrap a full line before the byte is applied
        len_w     = (i_len >= LEN_W'(LINE_SIZE - 1)) ? '0 : i_len;
        erase_hit = canon && (c == i_cfg.erase);
        nl_hit    = canon && !erase_hit && (c == ttyld_pkg::BYTE_NL);

        o_plan.hat   = !ign && esc;
        o_plan.chr   = !ign && (esc || (i_cfg.lflag[0] && c != ttyld_pkg::BYTE_DEL));
        o_plan.sig   = !ign && sig_hit;
        o_plan.erase = !ign && erase_hit && (len_w != '0);
        o_plan.nl    = !ign && nl_hit;
        o_plan.cr    = !ign && nl_hit && i_cfg.lflag[0];
        o_plan.pass  = !ign && !i_cfg.lflag[2] && !sig_hit;
        o_plan.st2   = !ign && canon && !erase_hit && !nl_hit && esc
                       && (len_w < LEN_W'(LINE_SIZE - 2));
        o_plan.st1   = !ign && canon && !erase_hit && !nl_hit && !o_plan.st2
                       && (len_w < LEN_W'(LINE_SIZE - 1));
        o_plan.byte_val = c;
        o_plan.echo_val = esc ? {1'b0, ~c[6], c[5:0]} : c;
        if (c == i_cfg.intr) begin
            o_plan.sig_code = ttyld_pkg::SIG_INTR;
        end else if (c == i_cfg.susp) begin
            o_plan.sig_code = ttyld_pkg::SIG_STOP;
        end else begin
            o_plan.sig_code = ttyld_pkg::SIG_QUIT;
        end

        if (!ign && canon) begin
            o_len_next = o_plan.erase ? len_w - 1'b1 : len_w;
        end else begin
            o_len_next = i_len;
        end
    end

endmodule

[hw/rtl/ttyld_line_ram.sv]
module ttyld_line_ram #(
    parameter int DEPTH = 32,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/tty_input_line_discipline.sv]
// Channel   Handshake                    Payload
// input     i_in_valid / o_in_stall      i_rx_byte
// result    o_out_valid / i_out_stall    o_out_kind, o_out_value, o_out_last
// config    i_cfg_valid / o_cfg_ready    i_cfg_index, i_cfg_data
//
// An item is taken while the sequencer is idle; its results then leave through the
// output register, and no new item is taken until the sequencer is back in idle.
// A newline drain reads each stored byte from the line memory (registered read), then emits it.
// An escaped store writes two memory entries, one per cycle; a plain store writes one.
// Reset clears the configuration to its defaults and empties the line; memory is not cleared.
// A stall on the result side holds the sequencer; o_in_stall stays high until the item is done.
module tty_input_line_discipline #(
    parameter int LINE_SIZE = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_rx_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [1:0] o_out_kind,
    output logic [7:0] o_out_value,
    output logic       o_out_last,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [2:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    localparam int LEN_W = $clog2(LINE_SIZE);

    ttyld_pkg::t_cfg   r_cfg;
    ttyld_pkg::t_state r_state, n_state;
    ttyld_pkg::t_plan  r_plan, n_plan;
    ttyld_pkg::t_plan  w_plan;
    logic [LEN_W-1:0]  r_len, n_len;
    logic [LEN_W-1:0]  r_idx, n_idx;
    logic [LEN_W-1:0]  w_len_next;
    logic              r_out_valid, n_out_valid;
    logic [1:0]        r_out_kind, n_out_kind;
    logic [7:0]        r_out_value, n_out_value;
    logic              r_out_last, n_out_last;
    logic              w_emit_ok;
    logic              w_mem_we;
    logic [7:0]        w_mem_wdata;
    logic              w_mem_re;
    logic [7:0]        w_mem_rdata;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != ttyld_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_kind  = r_out_kind;
    assign o_out_value = r_out_value;
    assign o_out_last  = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.iflag <= ttyld_pkg::RST_INPUT_FLAGS;
            r_cfg.lflag <= ttyld_pkg::RST_LOCAL_FLAGS;
            r_cfg.erase <= ttyld_pkg::RST_ERASE_CHAR;
            r_cfg.intr  <= ttyld_pkg::RST_INTR_CHAR;
            r_cfg.susp  <= ttyld_pkg::RST_SUSP_CHAR;
            r_cfg.quit  <= ttyld_pkg::RST_QUIT_CHAR;
            r_cfg.fg    <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                ttyld_pkg::CFG_INPUT_FLAGS: r_cfg.iflag <= i_cfg_data[3:0];
                ttyld_pkg::CFG_LOCAL_FLAGS: r_cfg.lflag <= i_cfg_data[2:0];
                ttyld_pkg::CFG_ERASE_CHAR:  r_cfg.erase <= i_cfg_data;
                ttyld_pkg::CFG_INTR_CHAR:   r_cfg.intr  <= i_cfg_data;
                ttyld_pkg::CFG_SUSP_CHAR:   r_cfg.susp  <= i_cfg_data;
                ttyld_pkg::CFG_QUIT_CHAR:   r_cfg.quit  <= i_cfg_data;
                ttyld_pkg::CFG_FOREGROUND:  r_cfg.fg    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    ttyld_decode #(
        .LINE_SIZE (LINE_SIZE),
        .LEN_W     (LEN_W)
    ) u_decode (
        .i_rx_byte  (i_rx_byte),
        .i_cfg      (r_cfg),
        .i_len      (r_len),
        .o_plan     (w_plan),
        .o_len_next (w_len_next)
    );

    // stores and drain reads belong to different items, so a read never meets a pending write
    ttyld_line_ram #(
        .DEPTH (LINE_SIZE),
        .AW    (LEN_W)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (r_len),
        .i_wdata (w_mem_wdata),
        .i_re    (w_mem_re),
        .i_raddr (r_idx),
        .o_rdata (w_mem_rdata)
    );

    assign w_emit_ok = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state     = r_state;
        n_plan      = r_plan;
        n_len       = r_len;
        n_idx       = r_idx;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_kind  = r_out_kind;
        n_out_value = r_out_value;
        n_out_last  = r_out_last;
        w_mem_we    = 1'b0;
        w_mem_wdata = r_plan.byte_val;
        w_mem_re    = 1'b0;

        case (r_state)
            ttyld_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_plan = w_plan;
                    n_len  = w_len_next;
                    n_idx  = '0;
                    if (w_plan.hat) begin
                        n_state = ttyld_pkg::S_HAT;
                    end else if (w_plan.chr) begin
                        n_state = ttyld_pkg::S_CHR;
                    end else begin
                        n_state = ttyld_pkg::after_echo(w_plan, w_len_next == '0);
                    end
                end
            end
            ttyld_pkg::S_HAT: begin
                if (w_emit_ok) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = ttyld_pkg::KIND_ECHO;
                    n_out_value = ttyld_pkg::BYTE_HAT;
                    n_out_last  = 1'b0;
                    n_state     = ttyld_pkg::S_CHR;
                end
            end
            ttyld_pkg::S_CHR: begin
                if (w_emit_ok) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = ttyld_pkg::KIND_ECHO;
                    n_out_value = r_plan.echo_val;
                    n_out_last  = !(r_plan.sig || r_plan.erase || r_plan.nl || r_plan.pass);
                    n_state     = ttyld_pkg::after_echo(r_plan, r_len == '0);
                end
            end
            ttyld_pkg::S_SIG: begin
                if (w_emit_ok) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = ttyld_pkg::KIND_SIGNAL;
                    n_out_value = r_plan.sig_code;
                    n_out_last  = 1'b1;
                    n_state     = ttyld_pkg::S_IDLE;
                end
            end
            ttyld_pkg::S_BS1: begin
                if (w_emit_ok) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = ttyld_pkg::KIND_ECHO;
                    n_out_value = ttyld_pkg::BYTE_BS;
                    n_out_last  = 1'b0;
                    n_state     = ttyld_pkg::S_SP;
                end
            end
            ttyld_pkg::S_SP: begin
                if (w_emit_ok) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = ttyld_pkg::KIND_ECHO;
                    n_out_value = ttyld_pkg::BYTE_SP;
                    n_out_last  = 1'b0;
                    n_state     = ttyld_pkg::S_BS2;
                end
            end
            ttyld_pkg::S_BS2: begin
                if (w_emit_ok) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = ttyld_pkg::KIND_ECHO;
                    n_out_value = ttyld_pkg::BYTE_BS;
                    n_out_last  = 1'b1;
                    n_state     = ttyld_pkg::S_IDLE;
                end
            end
            ttyld_pkg::S_RD: begin
                w_mem_re = 1'b1;
                n_state  = ttyld_pkg::S_DATA;
            end
            ttyld_pkg::S_DATA: begin
                if (w_emit_ok) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = ttyld_pkg::KIND_DATA;
                    n_out_value = w_mem_rdata;
                    n_out_last  = 1'b0;
                    n_idx       = r_idx + 1'b1;
                    n_state     = (r_idx == r_len - 1'b1) ? ttyld_pkg::S_NL : ttyld_pkg::S_RD;
                end
            end
            ttyld_pkg::S_NL: begin
                if (w_emit_ok) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = ttyld_pkg::KIND_DATA;
                    n_out_value = ttyld_pkg::BYTE_NL;
                    n_out_last  = !r_plan.cr;
                    n_len       = '0;
                    n_state     = r_plan.cr ? ttyld_pkg::S_CR : ttyld_pkg::S_IDLE;
                end
            end
            ttyld_pkg::S_CR: begin
                if (w_emit_ok) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = ttyld_pkg::KIND_ECHO;
                    n_out_value = ttyld_pkg::BYTE_CR;
                    n_out_last  = 1'b1;
                    n_state     = ttyld_pkg::S_IDLE;
                end
            end
            ttyld_pkg::S_PASS: begin
                if (w_emit_ok) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = ttyld_pkg::KIND_DATA;
                    n_out_value = r_plan.byte_val;
                    n_out_last  = 1'b1;
                    n_state     = ttyld_pkg::S_IDLE;
                end
            end
            ttyld_pkg::S_ST1: begin
                // an escaped byte stores the caret first, then its letter
                w_mem_we    = 1'b1;
                w_mem_wdata = r_plan.st2 ? ttyld_pkg::BYTE_HAT : r_plan.byte_val;
                n_len       = r_len + 1'b1;
                n_state     = r_plan.st2 ? ttyld_pkg::S_ST2 : ttyld_pkg::S_IDLE;
            end
            ttyld_pkg::S_ST2: begin
                w_mem_we    = 1'b1;
                w_mem_wdata = r_plan.echo_val;
                n_len       = r_len + 1'b1;
                n_state     = ttyld_pkg::S_IDLE;
            end
            default: begin
                n_state = ttyld_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ttyld_pkg::S_IDLE;
            r_len       <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_len       <= n_len;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_plan      <= n_plan;
        r_out_kind  <= n_out_kind;
        r_out_value <= n_out_value;
        r_out_last  <= n_out_last;
    end

`ifndef NO_ASSERTIONS
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len < LEN_W'(LINE_SIZE - 1) || r_len == LEN_W'(LINE_SIZE - 1))
        else $error("line length beyond line size");

    a_drain_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ttyld_pkg::S_DATA || r_state == ttyld_pkg::S_RD) |-> r_idx < r_len)
        else $error("drain index past line length");

    a_start_on_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ttyld_pkg::S_IDLE) && $past(r_state == ttyld_pkg::S_IDLE)
        |-> $past(i_in_valid))
        else $error("sequencer left idle without an item");

    a_store_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ttyld_pkg::S_ST2 |-> $past(r_state == ttyld_pkg::S_ST1))
        else $error("second store without first");
`endif

endmodule
